### rtl/annexb_pkg.sv
package annexb_pkg;

   // Room for the most result items one input byte can cause
   localparam int MaxRes = 6;
   localparam int CntW   = $clog2(MaxRes + 1);
   localparam int IdxW   = $clog2(MaxRes);

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] unit_type;
      logic       unit_first;
      logic       unit_last;
      logic       marker_long;
   } rsp_type;

   // Splitter state plus the results gathered while one byte is processed
   typedef struct packed {
      rsp_type [MaxRes-1:0] list;
      logic [CntW-1:0]      count;
      logic [1:0]           zero_run;
      logic                 in_unit;
      logic                 header_wait;
      logic [7:0]           held_byte;
      logic                 held_valid;
      logic                 held_first;
      logic [7:0]           cur_type;
      logic                 cur_long;
   } step_type;

endpackage

### rtl/annexb_start_code_splitter.sv
// A result passes the input register, the result batch register and the output register; unit
// bytes are held back one byte so the final one can carry unit_last.
// Throughput: one byte per cycle if rsp_ready is high and a byte yields at most one result;
// a byte with several results holds the input until the output register has taken its batch.
// Reset (synchronous, active high): no unit open, no pending zeros, queues empty, keep_marker 0.
module annexb_start_code_splitter
   import annexb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_buffer_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_unit_type,
   output logic       rsp_unit_first,
   output logic       rsp_unit_last,
   output logic       rsp_marker_long,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   function automatic step_type emit(step_type s, logic [7:0] b, logic first, logic last);
      rsp_type r;
      r.out_byte    = b;
      r.unit_type   = s.cur_type;
      r.unit_first  = first;
      r.unit_last   = last;
      r.marker_long = s.cur_long;
      if (s.count < CntW'(MaxRes)) begin
         s.list[s.count[IdxW-1:0]] = r;
         s.count = s.count + CntW'(1);
      end
      return s;
   endfunction

   function automatic step_type push_byte(step_type s, logic [7:0] b);
      logic first;
      first = !s.held_valid;
      if (s.held_valid) begin
         s = emit(s, s.held_byte, s.held_first, 1'b0);
      end
      s.held_byte  = b;
      s.held_first = first;
      s.held_valid = 1'b1;
      return s;
   endfunction

   function automatic step_type push_zeros(step_type s, logic [1:0] n);
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < n) begin
            s = push_byte(s, 8'h00);
         end
      end
      return s;
   endfunction

   function automatic step_type push_marker(step_type s);
      s = push_zeros(s, s.cur_long ? 2'd3 : 2'd2);
      s = push_byte(s, 8'h01);
      return s;
   endfunction

   function automatic step_type close_unit(step_type s);
      if (s.held_valid) begin
         s = emit(s, s.held_byte, s.held_first, 1'b1);
      end
      s.held_valid = 1'b0;
      s.held_first = 1'b0;
      return s;
   endfunction

   function automatic step_type unit_byte(step_type s, logic [7:0] b);
      if (b == 8'h00) begin
         if (s.zero_run != 2'd3) begin
            s.zero_run = s.zero_run + 2'd1;
         end else begin
            s = push_byte(s, 8'h00);
         end
      end else if (b == 8'h01 && s.zero_run >= 2'd2) begin
         s = close_unit(s);
         s.in_unit     = 1'b0;
         s.header_wait = 1'b1;
         s.cur_long    = (s.zero_run == 2'd3);
         s.zero_run    = 2'd0;
      end else begin
         s = push_zeros(s, s.zero_run);
         s = push_byte(s, b);
         s.zero_run = 2'd0;
      end
      return s;
   endfunction

   logic                 keep_marker_ff;
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_end_ff;

   logic [1:0]           zero_run_ff;
   logic                 in_unit_ff;
   logic                 header_wait_ff;
   logic [7:0]           held_byte_ff;
   logic                 held_valid_ff;
   logic                 held_first_ff;
   logic [7:0]           cur_type_ff;
   logic                 cur_long_ff;

   rsp_type [MaxRes-1:0] batch_ff;
   logic [CntW-1:0]      batch_cnt_ff;
   logic [CntW-1:0]      batch_idx_ff;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   step_type             step_in;
   logic                 batch_avail;
   logic                 out_load;
   logic                 batch_free;
   logic                 step_go;

   // One input byte through the splitter, results collected in order
   always_comb begin
      step_type s;
      s.list        = '0;
      s.count       = '0;
      s.zero_run    = zero_run_ff;
      s.in_unit     = in_unit_ff;
      s.header_wait = header_wait_ff;
      s.held_byte   = held_byte_ff;
      s.held_valid  = held_valid_ff;
      s.held_first  = held_first_ff;
      s.cur_type    = cur_type_ff;
      s.cur_long    = cur_long_ff;

      if (s.header_wait) begin
         // type byte: opens the unit and is also a content byte, after the start code if keep_marker_ff
         s.cur_type    = in_byte_ff;
         s.header_wait = 1'b0;
         s.in_unit     = 1'b1;
         s.held_valid  = 1'b0;
         s.zero_run    = 2'd0;
         if (keep_marker_ff) begin
            s = push_marker(s);
         end
         s = unit_byte(s, in_byte_ff);
      end else if (s.in_unit) begin
         s = unit_byte(s, in_byte_ff);
      end else begin
         if (in_byte_ff == 8'h00) begin
            if (s.zero_run != 2'd3) begin
               s.zero_run = s.zero_run + 2'd1;
            end
         end else if (in_byte_ff == 8'h01 && s.zero_run >= 2'd2) begin
            s.header_wait = 1'b1;
            s.cur_long    = (s.zero_run == 2'd3);
            s.zero_run    = 2'd0;
         end else begin
            s.zero_run = 2'd0;
         end
      end

      if (in_end_ff) begin
         if (s.in_unit) begin
            // trailing zeros belong to the unit at end of buffer
            s = push_zeros(s, s.zero_run);
            s = close_unit(s);
         end else if (s.header_wait && keep_marker_ff) begin
            s.cur_type   = 8'h00;
            s.held_valid = 1'b0;
            s = push_marker(s);
            s = close_unit(s);
         end
         s.zero_run    = 2'd0;
         s.in_unit     = 1'b0;
         s.header_wait = 1'b0;
         s.held_valid  = 1'b0;
         s.held_first  = 1'b0;
      end
      step_in = s;
   end

   assign batch_avail = (batch_idx_ff != batch_cnt_ff);
   assign out_load    = batch_avail && (!rsp_valid_ff || rsp_ready);
   assign batch_free  = !batch_avail || (out_load && (batch_idx_ff + CntW'(1) == batch_cnt_ff));
   assign step_go     = in_valid_ff && batch_free;
   assign req_ready   = !in_valid_ff || step_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_marker_ff <= 1'b0;
      end else if (csr_wr_en) begin
         keep_marker_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (step_go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_buffer_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff    <= 2'd0;
         in_unit_ff     <= 1'b0;
         header_wait_ff <= 1'b0;
         held_valid_ff  <= 1'b0;
         held_first_ff  <= 1'b0;
         held_byte_ff   <= 8'h00;
         cur_type_ff    <= 8'h00;
         cur_long_ff    <= 1'b0;
      end else if (step_go) begin
         zero_run_ff    <= step_in.zero_run;
         in_unit_ff     <= step_in.in_unit;
         header_wait_ff <= step_in.header_wait;
         held_valid_ff  <= step_in.held_valid;
         held_first_ff  <= step_in.held_first;
         held_byte_ff   <= step_in.held_byte;
         cur_type_ff    <= step_in.cur_type;
         cur_long_ff    <= step_in.cur_long;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_cnt_ff <= '0;
         batch_idx_ff <= '0;
      end else if (step_go) begin
         batch_cnt_ff <= step_in.count;
         batch_idx_ff <= '0;
      end else if (out_load) begin
         batch_idx_ff <= batch_idx_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (step_go) begin
         batch_ff <= step_in.list;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= batch_ff[batch_idx_ff[IdxW-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.out_byte;
   assign rsp_unit_type   = rsp_ff.unit_type;
   assign rsp_unit_first  = rsp_ff.unit_first;
   assign rsp_unit_last   = rsp_ff.unit_last;
   assign rsp_marker_long = rsp_ff.marker_long;

`ifndef NO_ASSERTIONS
   a_batch_idx_bound: assert property (@(posedge clock) disable iff (reset)
      batch_idx_ff <= batch_cnt_ff)
      else $error("batch read index past batch count");

   a_batch_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      batch_cnt_ff <= CntW'(MaxRes))
      else $error("batch count exceeds capacity");

   a_unit_or_header: assert property (@(posedge clock) disable iff (reset)
      !(in_unit_ff && header_wait_ff))
      else $error("open unit while waiting for type byte");

   a_held_first_valid: assert property (@(posedge clock) disable iff (reset)
      held_first_ff |-> held_valid_ff)
      else $error("held first flag without held byte");

   a_no_step_on_busy: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && batch_avail && !out_load) |=> $stable(batch_cnt_ff))
      else $error("batch overwritten before drained");
`endif

endmodule
